// ----- hw/rtl/bdhr_pkg.sv -----
package bdhr_pkg;

  localparam int unsigned TIME_BITS_DEF = 32;
  localparam int unsigned CFG_W         = 26;
  localparam int unsigned CFG_IDX_W     = 3;

  // register indexes on the configuration channel
  localparam logic [CFG_IDX_W-1:0] CFG_PULLUP        = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_DEBOUNCE      = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_HOLD          = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_DELAY  = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_PERIOD = CFG_IDX_W'(4);

  localparam logic             PULLUP_RST        = 1'b0;
  localparam logic [CFG_W-1:0] DEBOUNCE_RST      = CFG_W'(50000);
  localparam logic [CFG_W-1:0] HOLD_RST          = CFG_W'(1000000);
  localparam logic [CFG_W-1:0] REPEAT_DELAY_RST  = CFG_W'(500000);
  localparam logic [CFG_W-1:0] REPEAT_PERIOD_RST = CFG_W'(100000);

endpackage

// ----- hw/rtl/bdhr_in_if.sv -----
interface bdhr_in_if #(
  parameter int unsigned TIME_BITS = 32
);
  logic                 valid;
  logic                 ready;
  logic                 raw_level;
  logic [TIME_BITS-1:0] now_us;

  modport source (output valid, output raw_level, output now_us, input ready);
  modport sink   (input valid, input raw_level, input now_us, output ready);
endinterface

// ----- hw/rtl/bdhr_out_if.sv -----
interface bdhr_out_if;
  logic valid;
  logic ready;
  logic level;
  logic is_pressed;
  logic is_released;
  logic is_holding;
  logic is_repeating;
  logic press_event;
  logic release_event;
  logic hold_event;
  logic repeat_event;

  modport source (
    output valid, output level, output is_pressed, output is_released,
    output is_holding, output is_repeating, output press_event,
    output release_event, output hold_event, output repeat_event,
    input ready
  );
  modport sink (
    input valid, input level, input is_pressed, input is_released,
    input is_holding, input is_repeating, input press_event,
    input release_event, input hold_event, input repeat_event,
    output ready
  );
endinterface

// ----- hw/rtl/bdhr_cfg_if.sv -----
interface bdhr_cfg_if
  import bdhr_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] reg_idx;
  logic [CFG_W-1:0]     wdata;

  modport source (output valid, output reg_idx, output wdata, input ready);
  modport sink   (input valid, input reg_idx, input wdata, output ready);
endinterface

// ----- hw/rtl/button_debounce_hold_repeat.sv -----
// channel  | direction | payload
// ---------+-----------+--------------------------------------------------
// in_i     | sink      | raw_level, now_us
// out_o    | source    | level, is_pressed/released/holding/repeating, 4 events
// cfg_i    | sink      | reg_idx, wdata (always ready)
//
// one item per cycle sustained while out_o is ready; an item passes from in_i to
// out_o through the input register, then the result register
// all control state, timers and registers clear on rst_ni; registers take
// their documented defaults
// a stalled out_o holds the result register; in_i keeps taking one more item
// into the input register, then backs off until out_o drains
module button_debounce_hold_repeat
  import bdhr_pkg::*;
#(
  parameter int unsigned TIME_BITS = TIME_BITS_DEF
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  bdhr_in_if.sink        in_i,
  bdhr_out_if.source     out_o,
  bdhr_cfg_if.sink       cfg_i
);

  localparam int unsigned CMP_W = (TIME_BITS > CFG_W) ? TIME_BITS : CFG_W;

  // configuration
  logic             pullup_q, pullup_d;
  logic [CFG_W-1:0] debounce_q, debounce_d;
  logic [CFG_W-1:0] hold_q, hold_d;
  logic [CFG_W-1:0] rdelay_q, rdelay_d;
  logic [CFG_W-1:0] rperiod_q, rperiod_d;

  // button state
  logic                 raw_prev_q, raw_prev_d;
  logic                 stable_q, stable_d;
  logic                 pressed_q, pressed_d;
  logic                 released_q, released_d;
  logic                 holding_q, holding_d;
  logic                 repeating_q, repeating_d;
  logic [TIME_BITS-1:0] change_time_q, change_time_d;
  logic [TIME_BITS-1:0] repeat_time_q, repeat_time_d;

  // input register
  logic                 s1_valid_q;
  logic                 raw_q;
  logic [TIME_BITS-1:0] now_q;

  // result register
  logic out_valid_q;
  logic level_q, is_pressed_q, is_released_q, is_holding_q, is_repeating_q;
  logic press_ev_q, release_ev_q, hold_ev_q, repeat_ev_q;

  logic in_fire, s1_adv, cfg_fire;

  // item datapath
  logic                 raw_changed;
  logic [TIME_BITS-1:0] chg_time;
  logic                 hold_cur;
  logic [TIME_BITS-1:0] since_chg, since_rep;
  logic                 deb_ok, delay_ok, period_ok, hold_ok;
  logic                 it_raw_prev, it_stable, it_pressed, it_released;
  logic                 it_holding, it_repeating;
  logic [TIME_BITS-1:0] it_change_time, it_repeat_time;
  logic                 ev_press, ev_release, ev_hold, ev_repeat;

  assign s1_adv   = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_adv;
  assign in_fire  = in_i.valid && in_i.ready;
  assign cfg_i.ready = 1'b1;
  assign cfg_fire = cfg_i.valid;

  assign raw_changed = raw_q != raw_prev_q;
  assign chg_time    = raw_changed ? now_q : change_time_q;
  assign hold_cur    = raw_changed ? 1'b0 : holding_q;
  assign since_chg   = now_q - chg_time;
  assign since_rep   = now_q - repeat_time_q;

  assign deb_ok    = (debounce_q == '0) || (CMP_W'(since_chg) >= CMP_W'(debounce_q));
  assign delay_ok  = (rdelay_q != '0) && (CMP_W'(since_rep) >= CMP_W'(rdelay_q));
  assign period_ok = (rperiod_q != '0) && (CMP_W'(since_rep) >= CMP_W'(rperiod_q));
  assign hold_ok   = !hold_cur && (hold_q != '0) && (CMP_W'(since_chg) >= CMP_W'(hold_q));

  always_comb begin
    it_raw_prev    = raw_q;
    it_stable      = stable_q;
    it_pressed     = pressed_q;
    it_released    = released_q;
    it_holding     = hold_cur;
    it_repeating   = repeating_q;
    it_change_time = chg_time;
    it_repeat_time = repeat_time_q;
    ev_press       = 1'b0;
    ev_release     = 1'b0;
    ev_hold        = 1'b0;
    ev_repeat      = 1'b0;
    if (raw_q != stable_q) begin
      if (deb_ok) begin
        if (raw_q != pullup_q) begin
          it_repeat_time = now_q;
          it_pressed     = 1'b1;
          it_released    = 1'b0;
          ev_press       = 1'b1;
        end else begin
          it_pressed     = 1'b0;
          it_released    = 1'b1;
          it_repeating   = 1'b0;
          ev_release     = 1'b1;
        end
        it_stable = raw_q;
      end
    end else if (pressed_q) begin
      // first repeat enters the repeat phase, later ones run on the period
      if (!repeating_q) begin
        if (delay_ok) begin
          it_repeat_time = now_q;
          it_repeating   = 1'b1;
          ev_repeat      = 1'b1;
        end
      end else if (period_ok) begin
        it_repeat_time = now_q;
        ev_repeat      = 1'b1;
      end
      if (hold_ok) begin
        it_holding = 1'b1;
        ev_hold    = 1'b1;
      end
    end
  end

  always_comb begin
    pullup_d      = pullup_q;
    debounce_d    = debounce_q;
    hold_d        = hold_q;
    rdelay_d      = rdelay_q;
    rperiod_d     = rperiod_q;
    raw_prev_d    = raw_prev_q;
    stable_d      = stable_q;
    pressed_d     = pressed_q;
    released_d    = released_q;
    holding_d     = holding_q;
    repeating_d   = repeating_q;
    change_time_d = change_time_q;
    repeat_time_d = repeat_time_q;
    if (s1_adv) begin
      raw_prev_d    = it_raw_prev;
      stable_d      = it_stable;
      pressed_d     = it_pressed;
      released_d    = it_released;
      holding_d     = it_holding;
      repeating_d   = it_repeating;
      change_time_d = it_change_time;
      repeat_time_d = it_repeat_time;
    end
    if (cfg_fire) begin
      case (cfg_i.reg_idx)
        CFG_PULLUP: begin
          // idle level also resets the raw and debounced level
          pullup_d   = cfg_i.wdata[0];
          raw_prev_d = cfg_i.wdata[0];
          stable_d   = cfg_i.wdata[0];
        end
        CFG_DEBOUNCE:      debounce_d = cfg_i.wdata;
        CFG_HOLD:          hold_d     = cfg_i.wdata;
        CFG_REPEAT_DELAY:  rdelay_d   = cfg_i.wdata;
        CFG_REPEAT_PERIOD: rperiod_d  = cfg_i.wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pullup_q      <= PULLUP_RST;
      debounce_q    <= DEBOUNCE_RST;
      hold_q        <= HOLD_RST;
      rdelay_q      <= REPEAT_DELAY_RST;
      rperiod_q     <= REPEAT_PERIOD_RST;
      raw_prev_q    <= PULLUP_RST;
      stable_q      <= PULLUP_RST;
      pressed_q     <= 1'b0;
      released_q    <= 1'b0;
      holding_q     <= 1'b0;
      repeating_q   <= 1'b0;
      change_time_q <= '0;
      repeat_time_q <= '0;
      s1_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      pullup_q      <= pullup_d;
      debounce_q    <= debounce_d;
      hold_q        <= hold_d;
      rdelay_q      <= rdelay_d;
      rperiod_q     <= rperiod_d;
      raw_prev_q    <= raw_prev_d;
      stable_q      <= stable_d;
      pressed_q     <= pressed_d;
      released_q    <= released_d;
      holding_q     <= holding_d;
      repeating_q   <= repeating_d;
      change_time_q <= change_time_d;
      repeat_time_q <= repeat_time_d;
      if (in_fire) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      raw_q <= in_i.raw_level;
      now_q <= in_i.now_us;
    end
    if (s1_adv) begin
      level_q        <= it_stable;
      is_pressed_q   <= it_pressed;
      is_released_q  <= it_released;
      is_holding_q   <= it_holding;
      is_repeating_q <= it_repeating;
      press_ev_q     <= ev_press;
      release_ev_q   <= ev_release;
      hold_ev_q      <= ev_hold;
      repeat_ev_q    <= ev_repeat;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.level         = level_q;
  assign out_o.is_pressed    = is_pressed_q;
  assign out_o.is_released   = is_released_q;
  assign out_o.is_holding    = is_holding_q;
  assign out_o.is_repeating  = is_repeating_q;
  assign out_o.press_event   = press_ev_q;
  assign out_o.release_event = release_ev_q;
  assign out_o.hold_event    = hold_ev_q;
  assign out_o.repeat_event  = repeat_ev_q;

endmodule
